// File: rtl/dbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared types and codes for the deque/bag store.
// ----------------------------------------------------------------------------
package dbs_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int CMD_W      = 3;
   localparam int ERR_W      = 2;
   localparam int PORT_VAL_W = 32;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FRONT_RD,
      ST_BACK_RD,
      ST_CAPT,
      ST_DONE
   } dbs_state_type;

endpackage
`default_nettype wire

// File: rtl/deque_bag_store_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deque_bag_store_core
// Bounded double-ended queue with value search and remove-first-match.
//
//   channel | dir | beat contents (low bit first)
//   req     | in  | tdata: value[31:0]; tuser: cmd[2:0]
//   rsp     | out | tdata: front_value, back_value, count, found, error
//
// One item at a time through a single-port slot memory and one wrap adder.
// Push/pop/unused: EXEC, FRONT_RD, BACK_RD, CAPT, DONE; if empty, FRONT_RD to DONE.
// Contains, and remove with no match: the scan walks one slot a cycle to FRONT_RD.
// Remove at offset k: each later element is read, then written one slot forward.
// Synchronous reset empties the store at once; no clearing pass.
// A held result does not block the next accept; it stalls the next result.
// ----------------------------------------------------------------------------
module deque_bag_store_core #(
   parameter int DEPTH       = dbs_pkg::DEPTH_DEF,
   parameter int VALUE_WIDTH = dbs_pkg::VALUE_WIDTH_DEF,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int RSP_BITS   = 2 * dbs_pkg::PORT_VAL_W + CW + 1 + dbs_pkg::ERR_W,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [dbs_pkg::PORT_VAL_W-1:0]  req_tdata,  // value
   input  wire logic [dbs_pkg::CMD_W-1:0]       req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [RSP_W-1:0]                     rsp_tdata   // front, back, count, found, error
);
   import dbs_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [VALUE_WIDTH-1:0] slots_ff [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   dbs_state_type          state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   found_ff, found_in;
   logic [ERR_W-1:0]       err_ff, err_in;
   logic [CW-1:0]          ka_ff, ka_in;
   logic                   pend_ff, pend_in;
   logic [CW-1:0]          pend_k_ff, pend_k_in;
   logic [CW-1:0]          sk_ff, sk_in;
   logic [VALUE_WIDTH-1:0] front_ff, front_in;
   logic [VALUE_WIDTH-1:0] back_ff, back_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [CW-1:0]          addr_k;
   logic [CW:0]            addr_sum;
   logic [CW:0]            addr_wrap;
   logic [AW-1:0]          mem_addr;
   logic                   mem_we;
   logic                   wr_shift;
   logic [VALUE_WIDTH-1:0] mem_wdata;
   logic                   full;
   logic                   empty;
   logic                   hit;

   // head + offset, modulo DEPTH
   assign addr_sum  = {1'b0, CW'(head_ff)} + {1'b0, addr_k};
   assign addr_wrap = (addr_sum >= (CW + 1)'(DEPTH)) ? addr_sum - (CW + 1)'(DEPTH) : addr_sum;
   assign mem_addr  = addr_wrap[AW-1:0];
   assign mem_wdata = wr_shift ? rd_data_ff : val_ff;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign hit   = pend_ff && (rd_data_ff == val_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots_ff[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= slots_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      val_ff      <= val_in;
      found_ff    <= found_in;
      err_ff      <= err_in;
      ka_ff       <= ka_in;
      pend_ff     <= pend_in;
      pend_k_ff   <= pend_k_in;
      sk_ff       <= sk_in;
      front_ff    <= front_in;
      back_ff     <= back_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      found_in     = found_ff;
      err_in       = err_ff;
      ka_in        = ka_ff;
      pend_in      = pend_ff;
      pend_k_in    = pend_k_ff;
      sk_in        = sk_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      addr_k       = '0;
      mem_we       = 1'b0;
      wr_shift     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               val_in   = VALUE_WIDTH'(req_tdata);
               found_in = 1'b0;
               err_in   = ERR_OK;
               ka_in    = '0;
               pend_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FRONT_RD;
            case (cmd_ff)
               CMD_PUSH_FRONT: begin
                  addr_k = CW'(DEPTH - 1);
                  if (full) begin
                     err_in = ERR_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     head_in  = mem_addr;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_PUSH_BACK: begin
                  addr_k = count_ff;
                  if (full) begin
                     err_in = ERR_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_POP_FRONT: begin
                  addr_k = CW'(1);
                  if (empty) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     head_in  = mem_addr;
                     count_in = count_ff - CW'(1);
                  end
               end
               CMD_POP_BACK: begin
                  if (empty) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               CMD_CONTAINS, CMD_REMOVE: begin
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_FRONT_RD;
               end
            endcase
         end
         ST_SCAN: begin
            // read issued, then compared in the next cycle
            addr_k = ka_ff;
            if (hit) begin
               found_in = 1'b1;
               if (cmd_ff == CMD_REMOVE) begin
                  sk_in    = pend_k_ff;
                  state_in = ST_SHIFT_RD;
               end else begin
                  state_in = ST_FRONT_RD;
               end
            end else if (ka_ff >= count_ff) begin
               state_in = ST_FRONT_RD;
            end else begin
               pend_in   = 1'b1;
               pend_k_in = ka_ff;
               ka_in     = ka_ff + CW'(1);
            end
         end
         ST_SHIFT_RD: begin
            addr_k = sk_ff + CW'(1);
            if ((sk_ff + CW'(1)) < count_ff) begin
               state_in = ST_SHIFT_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_FRONT_RD;
            end
         end
         ST_SHIFT_WR: begin
            addr_k   = sk_ff;
            mem_we   = 1'b1;
            wr_shift = 1'b1;
            sk_in    = sk_ff + CW'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_FRONT_RD: begin
            addr_k = '0;
            if (empty) begin
               front_in = '0;
               back_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_BACK_RD;
            end
         end
         ST_BACK_RD: begin
            addr_k   = count_ff - CW'(1);
            front_in = rd_data_ff;
            state_in = ST_CAPT;
         end
         ST_CAPT: begin
            back_in  = rd_data_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({err_ff, found_ff, count_ff,
                                      PORT_VAL_W'(back_ff), PORT_VAL_W'(front_ff)});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/dbs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_checker
// Port-level checks for deque_bag_store_core, attached by bind.
// ----------------------------------------------------------------------------
module dbs_checker #(
   parameter int DEPTH       = dbs_pkg::DEPTH_DEF,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int RSP_BITS   = 2 * dbs_pkg::PORT_VAL_W + CW + 1 + dbs_pkg::ERR_W,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);
   import dbs_pkg::*;

   localparam int VW = PORT_VAL_W;

   logic [VW-1:0]    front_v;
   logic [VW-1:0]    back_v;
   logic [CW-1:0]    count_v;
   logic             found_v;
   logic [ERR_W-1:0] error_v;

   assign front_v = rsp_tdata[VW-1:0];
   assign back_v  = rsp_tdata[2*VW-1:VW];
   assign count_v = rsp_tdata[2*VW+CW-1:2*VW];
   assign found_v = rsp_tdata[2*VW+CW];
   assign error_v = rsp_tdata[2*VW+CW+ERR_W:2*VW+CW+1];

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp beat changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted while busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (count_v == '0) |-> (front_v == '0) && (back_v == '0))
      else $error("empty store reports nonzero ends");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count_v <= CW'(DEPTH)) &&
                     ((error_v == ERR_OK) || (error_v == ERR_FULL) || (error_v == ERR_EMPTY)) &&
                     ((error_v == ERR_OK) || !found_v))
      else $error("bad rsp status");

endmodule

bind deque_bag_store_core dbs_checker #(.DEPTH(DEPTH)) u_dbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
